### hw/rtl/pfsq_pkg.sv
// Package for the paired FIFO shortest-queue block.
// Holds the operation and status codes and the controller state type.
// No dependencies.
package pfsq_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH
	} pfsq_state_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

### hw/rtl/pfsq_queue_table.sv
// Per-queue record store (head, tail, count) with two read ports and one write port.
// Entries carry valid bits so that an entry never written reads as zero.
// No package dependencies.
module pfsq_queue_table #(
	parameter int NUM_QUEUES = 8,
	parameter int REC_BITS   = 19
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(NUM_QUEUES)-1:0] rd_addr_a,
	input  logic [$clog2(NUM_QUEUES)-1:0] rd_addr_b,
	output logic [REC_BITS-1:0]           rd_data_a,
	output logic [REC_BITS-1:0]           rd_data_b,
	input  logic                          wr_en,
	input  logic [$clog2(NUM_QUEUES)-1:0] wr_addr,
	input  logic [REC_BITS-1:0]           wr_data
);

	logic [REC_BITS-1:0]   mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] vld_q;
	logic [REC_BITS-1:0]   data_a_q;
	logic [REC_BITS-1:0]   data_b_q;
	logic                  vld_a_q;
	logic                  vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

### hw/rtl/pfsq_id_store.sv
// Shared ring storage for the ticket ids of all queues, one slot written and one slot read a cycle.
// The slot address is the queue number times the ring depth plus the ring position.
// No package dependencies.
module pfsq_id_store #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int WORD_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(NUM_QUEUES)-1:0]  wr_queue,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_slot,
	input  logic [WORD_BITS-1:0]           wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(NUM_QUEUES)-1:0]  rd_queue,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_slot,
	output logic [WORD_BITS-1:0]           rd_data
);

	localparam int Entries = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = $clog2(Entries);

	logic [WORD_BITS-1:0] mem [Entries];
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;

	assign wr_addr = AW'(AW'(wr_queue) * AW'(QUEUE_DEPTH)) + AW'(wr_slot);
	assign rd_addr = AW'(AW'(rd_queue) * AW'(QUEUE_DEPTH)) + AW'(rd_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/paired_fifo_shortest_queue.sv
// Paired FIFO shortest-queue block: NUM_QUEUES ring queues of ticket ids, queues 2k and 2k+1
// forming class pair k. An insert joins the shorter queue of its pair (the even queue on a
// tie); a remove pops the head of the named queue. Each accepted item gives one result.
// Items are handled one at a time: an insert, or any operation that fails, does a queue-table
// read and then the update in ST_LOOKUP; a successful remove also waits in ST_FETCH for the
// id store's registered read. A new item is taken once the result register is free or is
// being transferred in the same cycle. Depends on pfsq_pkg, pfsq_queue_table, pfsq_id_store.
module paired_fifo_shortest_queue
	import pfsq_pkg::*;
#(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [1:0]  ticket_class,
	input  logic [15:0] ticket_id,
	input  logic [2:0]  target_queue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  queue_used,
	output logic [15:0] id_out,
	output logic [6:0]  queue_length
);

	localparam int QW        = $clog2(NUM_QUEUES);
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int RW        = 2 * PW + CW;
	localparam int IW        = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int NUM_PAIRS = NUM_QUEUES / 2;

	pfsq_state_t state_q, state_d;

	logic          accept;
	logic          op_s1;
	logic [2:0]    tq_s1;
	logic          tq_bad_s1;
	logic [QW-1:0] east_s1;
	logic [IW-1:0] id_s1;
	logic [QW-1:0] pop_q_s2;
	logic [CW-1:0] pop_cnt_s2;

	logic [1:0]    pair;
	logic [QW-1:0] east;
	logic          tq_bad;
	logic [QW-1:0] tq_idx;

	logic [RW-1:0] rec_a;
	logic [RW-1:0] rec_b;
	logic [PW-1:0] head_a;
	logic [PW-1:0] tail_a;
	logic [CW-1:0] cnt_a;
	logic [PW-1:0] head_b;
	logic [PW-1:0] tail_b;
	logic [CW-1:0] cnt_b;

	logic          tab_wr_en;
	logic [QW-1:0] tab_wr_addr;
	logic [RW-1:0] tab_wr_data;
	logic          ids_wr_en;
	logic [QW-1:0] ids_wr_queue;
	logic [PW-1:0] ids_wr_slot;
	logic          ids_rd_en;
	logic [PW-1:0] ids_rd_slot;
	logic [IW-1:0] ids_rd_data;

	logic          res_load;
	logic [1:0]    res_status;
	logic [2:0]    res_queue;
	logic [15:0]   res_id;
	logic [6:0]    res_len;
	logic          pop_load;
	logic [QW-1:0] pop_q_d;
	logic [CW-1:0] pop_cnt_d;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [2:0]    queue_used_q;
	logic [15:0]   id_out_q;
	logic [6:0]    queue_length_q;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		pair = ticket_class;
		for (int i = 0; i < 4; i++) begin
			if (32'(pair) >= NUM_PAIRS) begin
				pair = pair - 2'(NUM_PAIRS);
			end
		end
		east   = QW'(32'(pair) * 2);
		tq_bad = 32'(target_queue) >= NUM_QUEUES;
		tq_idx = tq_bad ? '0 : QW'(target_queue);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			tq_s1     <= target_queue;
			tq_bad_s1 <= tq_bad;
			east_s1   <= east;
			id_s1     <= IW'(ticket_id);
		end
		if (pop_load) begin
			pop_q_s2   <= pop_q_d;
			pop_cnt_s2 <= pop_cnt_d;
		end
	end

	pfsq_queue_table #(
		.NUM_QUEUES (NUM_QUEUES),
		.REC_BITS   (RW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a ((operation == OP_INSERT) ? east : tq_idx),
		.rd_addr_b (east + 1'b1),
		.rd_data_a (rec_a),
		.rd_data_b (rec_b),
		.wr_en     (tab_wr_en),
		.wr_addr   (tab_wr_addr),
		.wr_data   (tab_wr_data)
	);

	assign {head_a, tail_a, cnt_a} = rec_a;
	assign {head_b, tail_b, cnt_b} = rec_b;

	pfsq_id_store #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WORD_BITS   (IW)
	) u_ids (
		.clk      (clk),
		.wr_en    (ids_wr_en),
		.wr_queue (ids_wr_queue),
		.wr_slot  (ids_wr_slot),
		.wr_data  (id_s1),
		.rd_en    (ids_rd_en),
		.rd_queue (tab_wr_addr),
		.rd_slot  (ids_rd_slot),
		.rd_data  (ids_rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (op_s1 == OP_REMOVE && !tq_bad_s1 && cnt_a != '0) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FETCH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		logic          pick_a;
		logic [QW-1:0] q;
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [CW-1:0] cnt;
		logic [PW-1:0] next_tail;
		logic [PW-1:0] next_head;

		pick_a    = cnt_a <= cnt_b;
		q         = (op_s1 == OP_INSERT && !pick_a) ? east_s1 + 1'b1 : east_s1;
		head      = (op_s1 == OP_INSERT && !pick_a) ? head_b : head_a;
		tail      = (op_s1 == OP_INSERT && !pick_a) ? tail_b : tail_a;
		cnt       = (op_s1 == OP_INSERT && !pick_a) ? cnt_b : cnt_a;
		next_tail = (32'(tail) == QUEUE_DEPTH - 1) ? '0 : tail + 1'b1;
		next_head = (32'(head) == QUEUE_DEPTH - 1) ? '0 : head + 1'b1;
		if (op_s1 == OP_REMOVE) begin
			q = tq_bad_s1 ? '0 : QW'(tq_s1);
		end

		tab_wr_en    = 1'b0;
		tab_wr_addr  = q;
		tab_wr_data  = {head, next_tail, cnt + 1'b1};
		ids_wr_en    = 1'b0;
		ids_wr_queue = q;
		ids_wr_slot  = tail;
		ids_rd_en    = 1'b0;
		ids_rd_slot  = head;
		res_load     = 1'b0;
		res_status   = STATUS_DONE;
		res_queue    = 3'(q);
		res_id       = 16'(id_s1);
		res_len      = 7'(cnt + 1'b1);
		pop_load     = 1'b0;
		pop_q_d      = q;
		pop_cnt_d    = cnt - 1'b1;

		case (state_q)
			ST_LOOKUP: begin
				if (op_s1 == OP_INSERT) begin
					res_load = 1'b1;
					if (32'(cnt) >= QUEUE_DEPTH) begin
						res_status = STATUS_FULL;
						res_len    = 7'(cnt);
					end else begin
						tab_wr_en = 1'b1;
						ids_wr_en = 1'b1;
					end
				end else if (tq_bad_s1 || cnt == '0) begin
					res_load   = 1'b1;
					res_status = STATUS_EMPTY;
					res_queue  = tq_s1;
					res_id     = '0;
					res_len    = '0;
				end else begin
					tab_wr_en   = 1'b1;
					tab_wr_data = {next_head, tail, cnt - 1'b1};
					ids_rd_en   = 1'b1;
					pop_load    = 1'b1;
				end
			end
			ST_FETCH: begin
				res_load  = 1'b1;
				res_queue = 3'(pop_q_s2);
				res_id    = 16'(ids_rd_data);
				res_len   = 7'(pop_cnt_s2);
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q       <= res_status;
			queue_used_q   <= res_queue;
			id_out_q       <= res_id;
			queue_length_q <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign queue_used   = queue_used_q;
	assign id_out       = id_out_q;
	assign queue_length = queue_length_q;

endmodule

### tb/tb_paired_fifo_shortest_queue.sv
// Self-checking testbench for paired_fifo_shortest_queue: a directed table, then random
// fill, drain and mixed traffic, each result checked against a typed table row or an
// in-bench queue predictor. Depends on pfsq_pkg and the paired_fifo_shortest_queue RTL.
`timescale 1ns / 1ps

module tb_paired_fifo_shortest_queue;
	import pfsq_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int NUM_QUEUES    = 8;
	localparam int QUEUE_DEPTH   = 64;
	localparam int RANDOM_ITEMS  = 550;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;
	localparam int TAIL_CYCLES   = 12;

	typedef struct packed {
		logic        op;
		logic [1:0]  cls;
		logic [15:0] id;
		logic [2:0]  tq;
	} ticket_op_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [2:0]  q;
		logic [15:0] idv;
		logic [6:0]  len;
	} queue_result_t;

	typedef struct packed {
		ticket_op_t    stim;
		logic          typed;
		queue_result_t want;
	} ticket_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = OP_INSERT;
	logic [1:0]  ticket_class = 2'd0;
	logic [15:0] ticket_id = 16'd0;
	logic [2:0]  target_queue = 3'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [2:0]  queue_used;
	logic [15:0] id_out;
	logic [6:0]  queue_length;

	logic [15:0] ring_ids [0:NUM_QUEUES-1][0:QUEUE_DEPTH-1];
	logic [5:0]  ring_head [0:NUM_QUEUES-1];
	logic [5:0]  ring_tail [0:NUM_QUEUES-1];
	logic [6:0]  ring_count [0:NUM_QUEUES-1];

	queue_result_t pending_results [$];

	int error_count = 0;
	int burst_left = 0;
	int accepted_items = 0;
	int inserts_done = 0;
	int removes_done = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int longest_queue = 0;
	int idle_cycles = 0;
	int rx_cycle = 0;
	int rx_hold = 0;
	int rx_mode = 0;

	ticket_row_t directed_table [0:20] = '{
		'{'{OP_REMOVE, 2'd0, 16'h0000, 3'd0}, 1'b1, '{STATUS_EMPTY, 3'd0, 16'h0000, 7'd0}},
		'{'{OP_REMOVE, 2'd3, 16'hFFFF, 3'd7}, 1'b1, '{STATUS_EMPTY, 3'd7, 16'h0000, 7'd0}},
		'{'{OP_INSERT, 2'd0, 16'h0000, 3'd7}, 1'b1, '{STATUS_DONE, 3'd0, 16'h0000, 7'd1}},
		'{'{OP_INSERT, 2'd0, 16'hFFFF, 3'd0}, 1'b1, '{STATUS_DONE, 3'd1, 16'hFFFF, 7'd1}},
		'{'{OP_INSERT, 2'd0, 16'h1234, 3'd5}, 1'b1, '{STATUS_DONE, 3'd0, 16'h1234, 7'd2}},
		'{'{OP_INSERT, 2'd3, 16'hA5A5, 3'd2}, 1'b1, '{STATUS_DONE, 3'd6, 16'hA5A5, 7'd1}},
		'{'{OP_INSERT, 2'd3, 16'h5A5A, 3'd1}, 1'b1, '{STATUS_DONE, 3'd7, 16'h5A5A, 7'd1}},
		'{'{OP_INSERT, 2'd1, 16'h8001, 3'd3}, 1'b0, '0},
		'{'{OP_INSERT, 2'd2, 16'h7FFE, 3'd4}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd1, 16'h0F0F, 3'd0}, 1'b1, '{STATUS_DONE, 3'd0, 16'h0000, 7'd1}},
		'{'{OP_REMOVE, 2'd2, 16'hF0F0, 3'd0}, 1'b1, '{STATUS_DONE, 3'd0, 16'h1234, 7'd0}},
		'{'{OP_REMOVE, 2'd0, 16'h0000, 3'd0}, 1'b1, '{STATUS_EMPTY, 3'd0, 16'h0000, 7'd0}},
		'{'{OP_REMOVE, 2'd0, 16'h0000, 3'd1}, 1'b1, '{STATUS_DONE, 3'd1, 16'hFFFF, 7'd0}},
		'{'{OP_REMOVE, 2'd3, 16'h0000, 3'd6}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd3, 16'h0000, 3'd7}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd1, 16'h0000, 3'd2}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd2, 16'h0000, 3'd4}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd1, 16'h0000, 3'd3}, 1'b1, '{STATUS_EMPTY, 3'd3, 16'h0000, 7'd0}},
		'{'{OP_REMOVE, 2'd2, 16'h0000, 3'd5}, 1'b1, '{STATUS_EMPTY, 3'd5, 16'h0000, 7'd0}},
		'{'{OP_INSERT, 2'd1, 16'hFFFF, 3'd0}, 1'b0, '0},
		'{'{OP_REMOVE, 2'd3, 16'hFFFF, 3'd2}, 1'b0, '0}
	};

	paired_fifo_shortest_queue #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (16)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.ticket_class(ticket_class),
		.ticket_id   (ticket_id),
		.target_queue(target_queue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.queue_used  (queue_used),
		.id_out      (id_out),
		.queue_length(queue_length)
	);

	always #CLK_HALF clk = ~clk;

	function automatic queue_result_t apply_ticket_op(input ticket_op_t t);
		queue_result_t r;
		logic [2:0] pick;
		r = '0;
		if (t.op == OP_INSERT) begin
			pick = (ring_count[{t.cls, 1'b0}] <= ring_count[{t.cls, 1'b1}]) ?
				{t.cls, 1'b0} : {t.cls, 1'b1};
			r.q = pick;
			r.idv = t.id;
			if (ring_count[pick] >= QUEUE_DEPTH) begin
				r.st = STATUS_FULL;
			end else begin
				ring_ids[pick][ring_tail[pick]] = t.id;
				ring_tail[pick] = ring_tail[pick] + 6'd1;
				ring_count[pick] = ring_count[pick] + 7'd1;
				r.st = STATUS_DONE;
			end
			r.len = ring_count[pick];
		end else if (ring_count[t.tq] == 0) begin
			r.st = STATUS_EMPTY;
			r.q = t.tq;
		end else begin
			r.st = STATUS_DONE;
			r.q = t.tq;
			r.idv = ring_ids[t.tq][ring_head[t.tq]];
			ring_head[t.tq] = ring_head[t.tq] + 6'd1;
			ring_count[t.tq] = ring_count[t.tq] - 7'd1;
			r.len = ring_count[t.tq];
		end
		return r;
	endfunction

	function automatic ticket_op_t pick_ticket_op(input int insert_pct, input int focus);
		ticket_op_t t;
		int tries;
		t.id = 16'($urandom);
		t.tq = 3'($urandom);
		t.cls = 2'($urandom);
		if (focus >= 0 && $urandom_range(0, 3) != 0)
			t.cls = 2'(focus);
		if ($urandom_range(1, 100) <= insert_pct) begin
			t.op = OP_INSERT;
		end else begin
			t.op = OP_REMOVE;
			if (focus >= 0 && $urandom_range(0, 1) == 1)
				t.tq = {2'(focus), 1'($urandom)};
			if ($urandom_range(0, 3) != 0)
				for (tries = 0; tries < 8 && ring_count[t.tq] == 0; tries++)
					t.tq = 3'($urandom);
		end
		return t;
	endfunction

	task automatic offer(input ticket_op_t t, input logic typed, input queue_result_t want);
		queue_result_t predicted;
		in_valid <= 1'b1;
		operation <= t.op;
		ticket_class <= t.cls;
		ticket_id <= t.id;
		target_queue <= t.tq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_ticket_op(t);
		pending_results.push_back(typed ? want : predicted);
		accepted_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 8);
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 2500 == 400)
				rx_hold <= HOLD_CYCLES;
			else if (rx_hold != 0)
				rx_hold <= rx_hold - 1;
			if (rx_cycle % 64 == 0)
				rx_mode <= $urandom_range(0, 3);
			if (rx_hold != 0) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= rx_cycle[2];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d queue %0d id 0x%0h length %0d",
					$time, status, queue_used, id_out, queue_length);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.st, status);
				check_field("queue_used", want.q, queue_used);
				check_field("id_out", want.idv, id_out);
				check_field("queue_length", want.len, queue_length);
				if (status == STATUS_FULL)
					full_seen++;
				else if (status == STATUS_EMPTY)
					empty_seen++;
				else if (want.st == STATUS_DONE && want.len > longest_queue)
					longest_queue = want.len;
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		ticket_op_t t;
		int i;
		int seg_len;
		int pct;
		int focus;
		int fill_class;
		int random_count;
		for (i = 0; i < NUM_QUEUES; i++) begin
			ring_head[i] = '0;
			ring_tail[i] = '0;
			ring_count[i] = '0;
		end
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed_table); i++) begin
			offer(directed_table[i].stim, directed_table[i].typed, directed_table[i].want);
			if (directed_table[i].stim.op == OP_INSERT)
				inserts_done++;
			else
				removes_done++;
		end

		random_count = 0;
		fill_class = $urandom_range(0, 3);
		for (i = 0; i < 140; i++) begin
			t = pick_ticket_op(100, fill_class);
			t.cls = 2'(fill_class);
			offer(t, 1'b0, '0);
			inserts_done++;
			random_count++;
		end
		for (i = 0; i < 140; i++) begin
			t = pick_ticket_op(10, fill_class);
			offer(t, 1'b0, '0);
			if (t.op == OP_INSERT)
				inserts_done++;
			else
				removes_done++;
			random_count++;
		end
		while (random_count < RANDOM_ITEMS) begin
			seg_len = $urandom_range(30, 90);
			case ($urandom_range(0, 3))
				0: pct = 15;
				1: pct = 50;
				2: pct = 50;
				default: pct = 85;
			endcase
			focus = $urandom_range(0, 4);
			if (focus == 4)
				focus = -1;
			for (i = 0; i < seg_len && random_count < RANDOM_ITEMS; i++) begin
				t = pick_ticket_op(pct, focus);
				offer(t, 1'b0, '0);
				if (t.op == OP_INSERT)
					inserts_done++;
				else
					removes_done++;
				random_count++;
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Covered %0d transfers: %0d inserts (%0d refused as full), %0d removes (%0d on empty queues).",
			accepted_items, inserts_done, full_seen, removes_done, empty_seen);
		$display("Longest queue reached %0d entries; the receiver held off once for %0d cycles.",
			longest_queue, HOLD_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
